>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, checked at each rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	`ASSERT_PROP(lbl, clk_s, rstn_s, !(cond), msg)

`endif

>>> src/dttf_pkg.sv
// ----------------------------------------------------------------------------
// dttf_pkg
// Types, codes and float constants shared by the text-to-float converter.
// ----------------------------------------------------------------------------
package dttf_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MINUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLUS  = 2'd1;

	localparam logic [7:0] MINUS_RST = 8'h99;
	localparam logic [7:0] PLUS_RST  = 8'h89;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;

	localparam logic [31:0] FP_ZERO  = 32'h0000_0000;
	localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
	localparam logic [31:0] FP_TEN   = 32'h4120_0000;
	localparam logic [31:0] FP_TENTH = 32'h3DCC_CCCD;
	localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;

	// Significand of 0.1 in double precision, value = mant * 2^-56.
	localparam logic [52:0] DT_MANT = 53'h1999999999999A;
	localparam logic [26:0] DT_MHI  = DT_MANT[52:26];
	localparam logic [25:0] DT_MLO  = DT_MANT[25:0];

	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_DSCALE
	} fpu_op_t;

	typedef struct packed {
		logic        start;
		fpu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} fpu_rsp_t;

	function automatic logic [31:0] digit_to_float(input logic [3:0] d);
		logic [31:0] f;
		unique case (d)
			4'd1: f = 32'h3F80_0000;
			4'd2: f = 32'h4000_0000;
			4'd3: f = 32'h4040_0000;
			4'd4: f = 32'h4080_0000;
			4'd5: f = 32'h40A0_0000;
			4'd6: f = 32'h40C0_0000;
			4'd7: f = 32'h40E0_0000;
			4'd8: f = 32'h4100_0000;
			4'd9: f = 32'h4110_0000;
			default: f = FP_ZERO;
		endcase
		return f;
	endfunction

endpackage

>>> src/decimal_text_to_float.sv
// ----------------------------------------------------------------------------
// decimal_text_to_float
// Streaming decimal text to IEEE single converter, one character per
// transaction, result on the terminating zero character.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  ----------------
//  char     in         char_valid / char_stall  char_code[7:0]
//  value    out        value_valid/value_stall  value_bits[31:0]
//  cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  Signs, dots, e/E and skipped characters are taken in the idle state with no
//  float operation. An integer digit stalls the input while the shared float
//  unit multiplies by ten, then adds; a fraction digit stalls it for a multiply,
//  an add, then the double-precision 0.1 scale over two partial products;
//  zero or special results finish sooner. The terminator runs the add, the
//  power loop of up to 8 squarings and 8 multiplies, and the final multiply,
//  plus any wait for the output register; every operation uses the one float unit.
//  Reset clears the parse state and loads the default sign codes.
//  char_stall is high while a character is being worked on; a finished value
//  waits in the output register while further characters are taken.
//
module decimal_text_to_float (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               char_valid,
	output logic                               char_stall,
	input  logic [7:0]                         char_code,
	output logic                               value_valid,
	input  logic                               value_stall,
	output logic [31:0]                        value_bits,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dttf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_data
);
	import dttf_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE,
		S_INT_MUL,
		S_INT_ADD,
		S_FR_MUL,
		S_FR_ADD,
		S_FR_SCL,
		S_SUM,
		S_POW_CHK,
		S_POW_ACC,
		S_POW_BASE,
		S_FINAL,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_EXP
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic [7:0]  minus_q, plus_q;
	logic        first_q, vneg_q, eneg_q;
	logic [31:0] int_q, frac_q, scale_q, digit_q;
	logic [7:0]  expacc_q, n_q;
	logic [31:0] base_q, acc_q, sum_q;
	logic        out_valid_q;
	logic [31:0] out_value_q;
	fpu_req_t    req_q;
	fpu_rsp_t    rsp;

	logic        accept, is_digit, is_dot, is_e;
	logic [3:0]  dval;
	logic [31:0] dfl;
	logic [11:0] exp_ext;
	logic [7:0]  exp_next;

	dttf_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	// Character decode for the idle state
	always_comb begin
		accept   = char_valid && !char_stall;
		is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		is_dot   = (char_code == CH_DOT);
		is_e     = (char_code == CH_E_LO) || (char_code == CH_E_UP);
		dval     = is_digit ? 4'(char_code - CH_ZERO) : 4'd0;
		dfl      = digit_to_float(dval);
		// exponent digits accumulate in integer, saturating at 255
		exp_ext  = {4'b0, expacc_q} * 12'd10 + {8'b0, dval};
		exp_next = (exp_ext > 12'd255) ? 8'hFF : exp_ext[7:0];
	end

	assign char_stall  = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign value_valid = out_valid_q;
	assign value_bits  = out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_INT;
			minus_q     <= MINUS_RST;
			plus_q      <= PLUS_RST;
			first_q     <= 1'b1;
			vneg_q      <= 1'b0;
			eneg_q      <= 1'b0;
			int_q       <= FP_ZERO;
			frac_q      <= FP_ZERO;
			scale_q     <= FP_TENTH;
			expacc_q    <= 8'd0;
			out_valid_q <= 1'b0;
			req_q       <= '0;
		end else begin
			// the user must issue config writes only while the block is idle; the block does not enforce it
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MINUS: minus_q <= cfg_data;
					REG_PLUS:  plus_q  <= cfg_data;
					default: ;
				endcase
			end

			req_q.start <= 1'b0;
			if (out_valid_q && !value_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (char_code == CH_NUL) begin
							// terminator: sum the parts, then scale by the power of ten
							req_q   <= '{start: 1'b1, op: OP_ADD, a: int_q, b: frac_q};
							state_q <= S_SUM;
						end else if (first_q && (char_code == minus_q)) begin
							first_q <= 1'b0;
							if (phase_q == PH_EXP) eneg_q <= 1'b1;
							else vneg_q <= 1'b1;
						end else if (first_q && (char_code == plus_q)) begin
							first_q <= 1'b0;
						end else begin
							first_q <= 1'b0;
							unique case (phase_q)
								PH_INT: begin
									if (is_digit) begin
										digit_q <= dfl;
										req_q   <= '{start: 1'b1, op: OP_MUL, a: int_q, b: FP_TEN};
										state_q <= S_INT_MUL;
									end else if (is_dot) begin
										phase_q <= PH_FRAC;
									end else if (is_e) begin
										phase_q <= PH_EXP;
										first_q <= 1'b1;
									end
								end
								PH_FRAC: begin
									if (is_digit) begin
										req_q   <= '{start: 1'b1, op: OP_MUL, a: scale_q, b: dfl};
										state_q <= S_FR_MUL;
									end else if (is_e) begin
										phase_q <= PH_EXP;
										first_q <= 1'b1;
									end
								end
								default: begin
									if (is_digit) expacc_q <= exp_next;
								end
							endcase
						end
					end
				end
				S_INT_MUL: begin
					if (rsp.done) begin
						req_q   <= '{start: 1'b1, op: OP_ADD, a: rsp.result, b: digit_q};
						state_q <= S_INT_ADD;
					end
				end
				S_INT_ADD: begin
					if (rsp.done) begin
						int_q   <= rsp.result;
						state_q <= S_IDLE;
					end
				end
				S_FR_MUL: begin
					if (rsp.done) begin
						req_q   <= '{start: 1'b1, op: OP_ADD, a: frac_q, b: rsp.result};
						state_q <= S_FR_ADD;
					end
				end
				S_FR_ADD: begin
					if (rsp.done) begin
						frac_q  <= rsp.result;
						req_q   <= '{start: 1'b1, op: OP_DSCALE, a: scale_q, b: FP_ZERO};
						state_q <= S_FR_SCL;
					end
				end
				S_FR_SCL: begin
					if (rsp.done) begin
						scale_q <= rsp.result;
						state_q <= S_IDLE;
					end
				end
				S_SUM: begin
					if (rsp.done) begin
						sum_q   <= {rsp.result[31] ^ vneg_q, rsp.result[30:0]};
						n_q     <= expacc_q;
						acc_q   <= FP_ONE;
						base_q  <= eneg_q ? FP_TENTH : FP_TEN;
						state_q <= S_POW_CHK;
					end
				end
				S_POW_CHK: begin
					// square-and-multiply, low exponent bit first
					if (n_q == 8'd0) begin
						req_q   <= '{start: 1'b1, op: OP_MUL, a: sum_q, b: acc_q};
						state_q <= S_FINAL;
					end else if (n_q[0]) begin
						req_q   <= '{start: 1'b1, op: OP_MUL, a: acc_q, b: base_q};
						state_q <= S_POW_ACC;
					end else begin
						req_q   <= '{start: 1'b1, op: OP_MUL, a: base_q, b: base_q};
						state_q <= S_POW_BASE;
					end
				end
				S_POW_ACC: begin
					if (rsp.done) begin
						acc_q   <= rsp.result;
						req_q   <= '{start: 1'b1, op: OP_MUL, a: base_q, b: base_q};
						state_q <= S_POW_BASE;
					end
				end
				S_POW_BASE: begin
					if (rsp.done) begin
						base_q  <= rsp.result;
						n_q     <= {1'b0, n_q[7:1]};
						state_q <= S_POW_CHK;
					end
				end
				S_FINAL: begin
					if (rsp.done) begin
						sum_q   <= rsp.result;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold until the output register is free, then restart the parse
					if (!out_valid_q || !value_stall) begin
						out_value_q <= sum_q;
						out_valid_q <= 1'b1;
						phase_q     <= PH_INT;
						first_q     <= 1'b1;
						vneg_q      <= 1'b0;
						eneg_q      <= 1'b0;
						int_q       <= FP_ZERO;
						frac_q      <= FP_ZERO;
						scale_q     <= FP_TENTH;
						expacc_q    <= 8'd0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_PROP(a_term_goes_busy, clk, arst_n, (accept && (char_code == CH_NUL)) |=> char_stall, "terminator did not start the finish sequence")
	`ASSERT_PROP(a_value_held, clk, arst_n, (value_valid && value_stall) |=> (value_valid && $stable(value_bits)), "stalled value transaction changed")
	`ASSERT_PROP(a_emit_stalls_input, clk, arst_n, (state_q == S_EMIT) |-> char_stall, "input taken while a value waits to be emitted")

endmodule

>>> src/dttf_fpu.sv
// ----------------------------------------------------------------------------
// dttf_fpu
// Shared multi-cycle float unit: single multiply, non-negative single add,
// and scale by double 0.1 with double then single rounding.
// ----------------------------------------------------------------------------
module dttf_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  dttf_pkg::fpu_req_t req,
	output dttf_pkg::fpu_rsp_t rsp
);
	import dttf_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		U_IDLE,
		U_DHI,
		U_NORM,
		U_RND53,
		U_RND24
	} ustate_t;

	localparam logic [79:0] ALL1 = {80{1'b1}};

	ustate_t             ustate_q;
	logic [79:0]         sig_q;
	logic signed [11:0]  exp_q;
	logic                sign_q;
	logic                dbl_q;
	logic [23:0]         ms_q;
	logic [49:0]         pp_q;
	logic                done_q;
	logic [31:0]         result_q;

	logic [7:0]  ea, eb, eea, eeb, diff;
	logic [23:0] ma, mb, mbig, msmall;
	logic        a_inf, b_inf, a_zero, b_zero, a_nan, b_nan, a_big;
	logic [47:0] prod;
	logic signed [11:0] mul_exp, add_exp, dsc_exp;
	logic [79:0] big_sig, small_full, small_sh, add_sum;
	logic        small_lost;
	logic [50:0] hi_prod;
	logic [6:0]  lz;

	logic signed [11:0] be, be_inc, sh;
	logic [79:0] sub_sh, src;
	logic        sub_lost, extra, g24, st24, inc24;
	logic [23:0] mant24;
	logic [24:0] r24;
	logic [31:0] rnd24;
	logic [52:0] m53;
	logic [53:0] r53;
	logic        g53, st53;

	function automatic logic [6:0] lzc80(input logic [79:0] v);
		logic [6:0] n;
		logic       found;
		n = 7'd0;
		found = 1'b0;
		for (int i = 79; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) found = 1'b1;
				else n = n + 7'd1;
			end
		end
		return n;
	endfunction

	// Operand unpack and first-step datapath
	always_comb begin
		ea     = req.a[30:23];
		eb     = req.b[30:23];
		ma     = {(ea != 8'd0), req.a[22:0]};
		mb     = {(eb != 8'd0), req.b[22:0]};
		eea    = (ea == 8'd0) ? 8'd1 : ea;
		eeb    = (eb == 8'd0) ? 8'd1 : eb;
		a_inf  = (ea == 8'hFF) && (req.a[22:0] == 23'd0);
		b_inf  = (eb == 8'hFF) && (req.b[22:0] == 23'd0);
		a_nan  = (ea == 8'hFF) && (req.a[22:0] != 23'd0);
		b_nan  = (eb == 8'hFF) && (req.b[22:0] != 23'd0);
		a_zero = (req.a[30:0] == 31'd0);
		b_zero = (req.b[30:0] == 31'd0);

		prod    = ma * mb;
		mul_exp = $signed({4'b0, eea}) + $signed({4'b0, eeb}) - 12'sd300;

		a_big      = (eea >= eeb);
		diff       = a_big ? (eea - eeb) : (eeb - eea);
		mbig       = a_big ? ma : mb;
		msmall     = a_big ? mb : ma;
		big_sig    = {1'b0, mbig, 55'b0};
		small_full = {1'b0, msmall, 55'b0};
		small_sh   = small_full >> diff;
		small_lost = |(small_full & ~(ALL1 << diff));
		add_sum    = big_sig + {small_sh[79:1], small_sh[0] | small_lost};
		add_exp    = $signed({4'b0, (a_big ? eea : eeb)}) - 12'sd205;

		dsc_exp = $signed({4'b0, eea}) - 12'sd206;
		hi_prod = ms_q * DT_MHI;
		lz      = lzc80(sig_q);
	end

	// Rounding to single (normal, subnormal, overflow) and to double width
	always_comb begin
		be       = exp_q + 12'sd206;
		be_inc   = be + 12'sd1;
		sh       = 12'sd1 - be;
		sub_sh   = sig_q >> $unsigned(sh);
		sub_lost = |(sig_q & ~(ALL1 << $unsigned(sh)));
		if (be >= 12'sd1) begin
			src   = sig_q;
			extra = 1'b0;
		end else begin
			src   = sub_sh;
			extra = sub_lost;
		end
		mant24 = src[79:56];
		g24    = src[55];
		st24   = (|src[54:0]) | extra;
		inc24  = g24 & (st24 | mant24[0]);
		r24    = {1'b0, mant24} + {24'b0, inc24};
		if (be >= 12'sd255) begin
			rnd24 = {sign_q, 8'hFF, 23'b0};
		end else if (be >= 12'sd1) begin
			if (r24[24]) begin
				rnd24 = (be_inc >= 12'sd255) ? {sign_q, 8'hFF, 23'b0}
					: {sign_q, be_inc[7:0], 23'b0};
			end else begin
				rnd24 = {sign_q, be[7:0], r24[22:0]};
			end
		end else begin
			rnd24 = {sign_q, 7'b0, r24[23], r24[22:0]};
		end

		m53  = sig_q[79:27];
		g53  = sig_q[26];
		st53 = |sig_q[25:0];
		r53  = {1'b0, m53} + {53'b0, g53 & (st53 | m53[0])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ustate_q <= U_IDLE;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ustate_q)
				U_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							OP_MUL: begin
								sign_q <= req.a[31] ^ req.b[31];
								if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
									result_q <= FP_QNAN;
									done_q   <= 1'b1;
								end else if (a_inf || b_inf) begin
									result_q <= {req.a[31] ^ req.b[31], 8'hFF, 23'b0};
									done_q   <= 1'b1;
								end else begin
									sig_q    <= {32'b0, prod};
									exp_q    <= mul_exp;
									dbl_q    <= 1'b0;
									ustate_q <= U_NORM;
								end
							end
							OP_ADD: begin
								sign_q <= 1'b0;
								if (a_inf || b_inf) begin
									result_q <= {1'b0, 8'hFF, 23'b0};
									done_q   <= 1'b1;
								end else begin
									sig_q    <= add_sum;
									exp_q    <= add_exp;
									dbl_q    <= 1'b0;
									ustate_q <= U_NORM;
								end
							end
							OP_DSCALE: begin
								sign_q   <= 1'b0;
								ms_q     <= ma;
								pp_q     <= ma * DT_MLO;
								exp_q    <= dsc_exp;
								dbl_q    <= 1'b1;
								ustate_q <= U_DHI;
							end
							default: begin
								result_q <= FP_QNAN;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				U_DHI: begin
					sig_q    <= ({29'b0, hi_prod} << 26) + {30'b0, pp_q};
					ustate_q <= U_NORM;
				end
				U_NORM: begin
					if (sig_q == 80'd0) begin
						result_q <= {sign_q, 31'b0};
						done_q   <= 1'b1;
						ustate_q <= U_IDLE;
					end else begin
						sig_q    <= sig_q << lz;
						exp_q    <= exp_q - $signed({5'b0, lz});
						ustate_q <= dbl_q ? U_RND53 : U_RND24;
					end
				end
				U_RND53: begin
					if (r53[53]) begin
						sig_q <= {1'b1, 79'b0};
						exp_q <= exp_q + 12'sd1;
					end else begin
						sig_q <= {r53[52:0], 27'b0};
					end
					ustate_q <= U_RND24;
				end
				U_RND24: begin
					result_q <= rnd24;
					done_q   <= 1'b1;
					ustate_q <= U_IDLE;
				end
				default: ustate_q <= U_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

	`ASSERT_NEVER(a_start_when_busy, clk, arst_n, req.start && (ustate_q != U_IDLE), "fpu start while busy")
	`ASSERT_PROP(a_done_has_cause, clk, arst_n, rsp.done |-> $past((ustate_q != U_IDLE) || req.start), "fpu done without work")
	`ASSERT_PROP(a_done_in_idle, clk, arst_n, rsp.done |-> (ustate_q == U_IDLE), "fpu done outside idle")

endmodule
